// ----- src/bcdclk_pkg.sv -----
// shared types, constants and digit step functions for the bcd clock
`timescale 1ns / 1ps
package bcdclk_pkg;

	localparam logic [3:0] ONES_MAX       = 4'd9;
	localparam logic [2:0] TENS_MAX       = 3'd5;
	localparam logic [1:0] HOUR_TENS_MAX  = 2'd2;
	localparam logic [3:0] HOUR_ONES_LAST = 4'd3;

	localparam logic [15:0] MS_PER_SECOND_RST = 16'd1000;
	localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd200;
	localparam logic [7:0]  MUX_MS_RST        = 8'd2;

	localparam logic [2:0] POS_HOUR_TENS   = 3'd0;
	localparam logic [2:0] POS_HOUR_ONES   = 3'd1;
	localparam logic [2:0] POS_MINUTE_TENS = 3'd2;
	localparam logic [2:0] POS_MINUTE_ONES = 3'd3;
	localparam logic [2:0] POS_SECOND_TENS = 3'd4;
	localparam logic [2:0] POS_SECOND_ONES = 3'd5;

	typedef enum logic [1:0] {
		REG_MS_PER_SECOND = 2'd0,
		REG_DEBOUNCE_MS   = 2'd1,
		REG_MUX_MS        = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic tick;
		logic hour_button;
		logic minute_button;
		logic second_button;
		logic clear_button;
	} in_item_t;

	typedef struct packed {
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic [2:0] second_tens;
		logic [3:0] second_ones;
		logic [2:0] shown_position;
		logic [3:0] shown_value;
	} out_item_t;

	typedef struct packed {
		logic [1:0] tens;
		logic [3:0] ones;
	} hour_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} pair_t;

	typedef struct packed {
		hour_t hour;
		pair_t minute;
		pair_t second;
	} clk_time_t;

	// per item controls for the time keeper
	typedef struct packed {
		logic tick;
		logic hour;
		logic minute;
		logic second;
		logic clear;
	} time_ctrl_t;

	function automatic logic [3:0] ones_step(logic [3:0] d);
		return (d >= ONES_MAX) ? 4'd0 : 4'(d + 4'd1);
	endfunction

	function automatic logic [2:0] tens_step(logic [2:0] d);
		return (d >= TENS_MAX) ? 3'd0 : 3'(d + 3'd1);
	endfunction

	function automatic pair_t pair_step(pair_t p);
		pair_t r;
		r.ones = ones_step(p.ones);
		r.tens = (r.ones == 4'd0) ? tens_step(p.tens) : p.tens;
		return r;
	endfunction

	// true when the pair steps from 59 back to 00
	function automatic logic pair_wrap(pair_t p);
		return (p.ones >= ONES_MAX) && (p.tens >= TENS_MAX);
	endfunction

	function automatic hour_t hour_step(hour_t h);
		hour_t r;
		r.ones = ones_step(h.ones);
		r.tens = h.tens;
		if (r.ones == 4'd0) begin
			r.tens = (h.tens >= HOUR_TENS_MAX) ? 2'd0 : 2'(h.tens + 2'd1);
		end
		if (r.tens >= HOUR_TENS_MAX && r.ones > HOUR_ONES_LAST) begin
			r.tens = 2'd0;
			r.ones = 4'd0;
		end
		return r;
	endfunction

endpackage

// ----- src/bcdclk_time.sv -----
// time keeper: bcd digits, set buttons, clear and the second counter
`timescale 1ns / 1ps
module bcdclk_time import bcdclk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  time_ctrl_t  ctrl,
	input  logic [15:0] ms_per_second,
	output clk_time_t   time_nxt
);

	clk_time_t   time_q;
	logic [15:0] ms_in_second_q;
	logic [15:0] ms_nxt;
	logic [16:0] ms_inc;
	logic        sec_wrap;
	logic        min_wrap;

	always_comb begin
		time_nxt = time_q;
		ms_nxt   = ms_in_second_q;
		ms_inc   = {1'b0, ms_in_second_q} + 17'd1;
		sec_wrap = 1'b0;
		min_wrap = 1'b0;
		if (ctrl.hour) begin
			time_nxt.hour = hour_step(time_nxt.hour);
		end
		if (ctrl.minute) begin
			time_nxt.minute = pair_step(time_nxt.minute);
		end
		if (ctrl.second) begin
			time_nxt.second = pair_step(time_nxt.second);
		end
		if (ctrl.clear) begin
			time_nxt = '0;
			ms_nxt   = '0;
		end
		if (ctrl.tick && !ctrl.clear) begin
			if (ms_inc >= {1'b0, ms_per_second}) begin
				ms_nxt          = '0;
				sec_wrap        = pair_wrap(time_nxt.second);
				time_nxt.second = pair_step(time_nxt.second);
				if (sec_wrap) begin
					min_wrap        = pair_wrap(time_nxt.minute);
					time_nxt.minute = pair_step(time_nxt.minute);
					if (min_wrap) begin
						time_nxt.hour = hour_step(time_nxt.hour);
					end
				end
			end else begin
				ms_nxt = ms_inc[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q         <= '0;
			ms_in_second_q <= '0;
		end else if (en) begin
			time_q         <= time_nxt;
			ms_in_second_q <= ms_nxt;
		end
	end

endmodule

// ----- src/bcd_clock_with_set_and_mux_core.sv -----
// top level of the 24-hour bcd clock with set buttons and display scan
//
// Each input item is one millisecond tick flag plus four button levels; each
// accepted item yields exactly one result item with the time after that item
// and the display digit now selected. The block takes one item per clock
// cycle unless the output stalls: an input register feeds one pass of counter
// and bcd carry logic that updates the clock state and loads the result
// register. The result register holds while the output is stalled, and the
// input register absorbs one more item before in_ready drops. Registers:
// 0 ms_per_second, 1 debounce_ms, 2 mux_ms, written through cfg_we/cfg_index/
// cfg_data by the user only while the block is idle; the block does not check.
`timescale 1ns / 1ps
module bcd_clock_with_set_and_mux_core import bcdclk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] ms_per_second_q;
	logic [15:0] debounce_ms_q;
	logic [7:0]  mux_ms_q;

	logic        in_valid_s1;
	in_item_t    in_s1;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [15:0] press_q;
	logic [7:0]  digit_cnt_q;
	logic [2:0]  pos_q;

	logic        advance;
	logic [15:0] press_inc;
	logic [15:0] press_nxt;
	logic        armed;
	time_ctrl_t  ctrl;
	clk_time_t   time_nxt;
	logic [8:0]  digit_inc;
	logic [7:0]  digit_cnt_nxt;
	logic [2:0]  pos_nxt;
	logic [3:0]  shown_nxt;

	assign advance   = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_per_second_q <= MS_PER_SECOND_RST;
			debounce_ms_q   <= DEBOUNCE_MS_RST;
			mux_ms_q        <= MUX_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MS_PER_SECOND: ms_per_second_q <= cfg_data;
				REG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_data;
				REG_MUX_MS:        mux_ms_q        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// press timer and button gating
	always_comb begin
		press_inc = press_q;
		if (in_s1.tick && press_q != 16'hFFFF) begin
			press_inc = 16'(press_q + 16'd1);
		end
		armed       = press_inc > debounce_ms_q;
		ctrl.tick   = in_s1.tick;
		ctrl.hour   = armed && in_s1.hour_button;
		ctrl.minute = armed && in_s1.minute_button;
		ctrl.second = armed && in_s1.second_button;
		ctrl.clear  = armed && in_s1.clear_button;
		press_nxt   = (ctrl.hour || ctrl.minute || ctrl.second || ctrl.clear) ?
			16'd0 : press_inc;
	end

	bcdclk_time u_time (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.ctrl          (ctrl),
		.ms_per_second (ms_per_second_q),
		.time_nxt      (time_nxt)
	);

	// display scan
	always_comb begin
		digit_inc     = {1'b0, digit_cnt_q} + 9'd1;
		digit_cnt_nxt = digit_cnt_q;
		pos_nxt       = pos_q;
		if (in_s1.tick) begin
			if (digit_inc >= {1'b0, mux_ms_q}) begin
				digit_cnt_nxt = '0;
				pos_nxt       = (pos_q >= POS_SECOND_ONES) ? POS_HOUR_TENS :
					3'(pos_q + 3'd1);
			end else begin
				digit_cnt_nxt = digit_inc[7:0];
			end
		end
		unique case (pos_nxt)
			POS_HOUR_TENS:   shown_nxt = {2'b00, time_nxt.hour.tens};
			POS_HOUR_ONES:   shown_nxt = time_nxt.hour.ones;
			POS_MINUTE_TENS: shown_nxt = {1'b0, time_nxt.minute.tens};
			POS_MINUTE_ONES: shown_nxt = time_nxt.minute.ones;
			POS_SECOND_TENS: shown_nxt = {1'b0, time_nxt.second.tens};
			POS_SECOND_ONES: shown_nxt = time_nxt.second.ones;
			default:         shown_nxt = 4'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			press_q     <= '0;
			digit_cnt_q <= '0;
			pos_q       <= '0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				press_q     <= press_nxt;
				digit_cnt_q <= digit_cnt_nxt;
				pos_q       <= pos_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			out_q.hour_tens      <= time_nxt.hour.tens;
			out_q.hour_ones      <= time_nxt.hour.ones;
			out_q.minute_tens    <= time_nxt.minute.tens;
			out_q.minute_ones    <= time_nxt.minute.ones;
			out_q.second_tens    <= time_nxt.second.tens;
			out_q.second_ones    <= time_nxt.second.ones;
			out_q.shown_position <= pos_nxt;
			out_q.shown_value    <= shown_nxt;
		end
	end

endmodule

// ----- src/bcdclk_checker.sv -----
// port level checks for the bcd clock, bound to the top level
`timescale 1ns / 1ps
module bcdclk_checker import bcdclk_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input out_item_t   out_data
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an empty output stage never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// time on a result is a legal 24-hour time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hour_ones <= ONES_MAX && out_data.minute_ones <= ONES_MAX &&
			out_data.second_ones <= ONES_MAX && out_data.minute_tens <= TENS_MAX &&
			out_data.second_tens <= TENS_MAX &&
			!(out_data.hour_tens == HOUR_TENS_MAX && out_data.hour_ones > HOUR_ONES_LAST) &&
			out_data.hour_tens <= HOUR_TENS_MAX)
		else $error("illegal time on result");

	// shown digit matches at three of the six positions
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.shown_position <= POS_SECOND_ONES &&
			(out_data.shown_position != POS_HOUR_TENS ||
				out_data.shown_value == {2'b00, out_data.hour_tens}) &&
			(out_data.shown_position != POS_MINUTE_ONES ||
				out_data.shown_value == out_data.minute_ones) &&
			(out_data.shown_position != POS_SECOND_ONES ||
				out_data.shown_value == out_data.second_ones))
		else $error("shown value does not match selected digit");

endmodule

bind bcd_clock_with_set_and_mux_core bcdclk_checker u_bcdclk_checker (.*);

// ----- tb/sv/bcd_clock_with_set_and_mux_core_test.sv -----
// testbench for the bcd clock core: every result item checked against a predicted display
`timescale 1ns / 1ps
module bcd_clock_with_set_and_mux_core_test;
	import bcdclk_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	bcd_clock_with_set_and_mux_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted clock state and register copies
	logic [3:0]  digit_q [6];
	logic [15:0] sec_ms;
	logic [15:0] press_ms;
	logic [7:0]  scan_ms;
	logic [2:0]  scan_pos;
	logic [15:0] sec_period;
	logic [15:0] debounce_len;
	logic [7:0]  scan_period;

	out_item_t display_due [$];
	int        mismatches = 0;
	logic      steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [3:0] bump(logic [3:0] d, logic [3:0] limit);
		return (d >= limit) ? 4'd0 : 4'(d + 4'd1);
	endfunction

	function automatic void advance_hour();
		digit_q[POS_HOUR_ONES] = bump(digit_q[POS_HOUR_ONES], ONES_MAX);
		if (digit_q[POS_HOUR_ONES] == 4'd0) begin
			digit_q[POS_HOUR_TENS] = bump(digit_q[POS_HOUR_TENS], 4'(HOUR_TENS_MAX));
		end
		if (digit_q[POS_HOUR_TENS] >= 4'(HOUR_TENS_MAX)
				&& digit_q[POS_HOUR_ONES] > HOUR_ONES_LAST) begin
			digit_q[POS_HOUR_TENS] = 4'd0;
			digit_q[POS_HOUR_ONES] = 4'd0;
		end
	endfunction

	// true when the pair wrapped back to 00
	function automatic logic advance_pair(logic [2:0] tens);
		digit_q[3'(tens + 3'd1)] = bump(digit_q[3'(tens + 3'd1)], ONES_MAX);
		if (digit_q[3'(tens + 3'd1)] != 4'd0) begin
			return 1'b0;
		end
		digit_q[tens] = bump(digit_q[tens], 4'(TENS_MAX));
		return digit_q[tens] == 4'd0;
	endfunction

	function automatic out_item_t next_display(in_item_t it);
		out_item_t r;
		logic      cleared;
		logic      acted;
		cleared = 1'b0;
		acted = 1'b0;
		if (it.tick && press_ms != 16'hFFFF) begin
			press_ms++;
		end
		if (press_ms > debounce_len) begin
			if (it.hour_button) begin
				advance_hour();
				acted = 1'b1;
			end
			if (it.minute_button) begin
				void'(advance_pair(POS_MINUTE_TENS));
				acted = 1'b1;
			end
			if (it.second_button) begin
				void'(advance_pair(POS_SECOND_TENS));
				acted = 1'b1;
			end
			if (it.clear_button) begin
				foreach (digit_q[i]) digit_q[i] = 4'd0;
				sec_ms = 16'd0;
				cleared = 1'b1;
				acted = 1'b1;
			end
			if (acted) begin
				press_ms = 16'd0;
			end
		end
		if (it.tick && !cleared) begin
			if (int'(sec_ms) + 1 >= int'(sec_period)) begin
				sec_ms = 16'd0;
				if (advance_pair(POS_SECOND_TENS) && advance_pair(POS_MINUTE_TENS)) begin
					advance_hour();
				end
			end else begin
				sec_ms++;
			end
		end
		if (it.tick) begin
			if (int'(scan_ms) + 1 >= int'(scan_period)) begin
				scan_ms = 8'd0;
				scan_pos = (scan_pos >= POS_SECOND_ONES) ? POS_HOUR_TENS : 3'(scan_pos + 3'd1);
			end else begin
				scan_ms++;
			end
		end
		r.hour_tens = digit_q[POS_HOUR_TENS][1:0];
		r.hour_ones = digit_q[POS_HOUR_ONES];
		r.minute_tens = digit_q[POS_MINUTE_TENS][2:0];
		r.minute_ones = digit_q[POS_MINUTE_ONES];
		r.second_tens = digit_q[POS_SECOND_TENS][2:0];
		r.second_ones = digit_q[POS_SECOND_ONES];
		r.shown_position = scan_pos;
		r.shown_value = (scan_pos <= POS_SECOND_ONES) ? digit_q[scan_pos] : 4'd0;
		return r;
	endfunction

	function automatic in_item_t sample_of(logic tick, logic hour, logic minute,
			logic second, logic clear);
		in_item_t it;
		it.tick = tick;
		it.hour_button = hour;
		it.minute_button = minute;
		it.second_button = second;
		it.clear_button = clear;
		return it;
	endfunction

	function automatic int idle_cycles();
		return steady ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		gap = idle_cycles();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		display_due.push_back(next_display(it));
	endtask

	task automatic wait_idle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (display_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (display_due.size() != 0) begin
			$error("%0d expected result items never arrived", display_due.size());
			mismatches++;
			display_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_MS_PER_SECOND: sec_period = value;
			REG_DEBOUNCE_MS:   debounce_len = value;
			REG_MUX_MS:        scan_period = value[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(logic [15:0] sec, logic [15:0] deb, logic [15:0] mux_word);
		wait_idle();
		write_reg(REG_MS_PER_SECOND, sec);
		write_reg(REG_DEBOUNCE_MS, deb);
		write_reg(REG_MUX_MS, mux_word);
	endtask

	task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	initial begin : display_monitor
		int        stall;
		out_item_t want;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		forever begin
			stall = idle_cycles();
			repeat (stall) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (display_due.size() == 0) begin
				$error("result item with no expectation waiting");
				mismatches++;
			end else begin
				want = display_due.pop_front();
				compare_field("hour_tens", 4'(want.hour_tens), 4'(out_data.hour_tens));
				compare_field("hour_ones", want.hour_ones, out_data.hour_ones);
				compare_field("minute_tens", 4'(want.minute_tens), 4'(out_data.minute_tens));
				compare_field("minute_ones", want.minute_ones, out_data.minute_ones);
				compare_field("second_tens", 4'(want.second_tens), 4'(out_data.second_tens));
				compare_field("second_ones", want.second_ones, out_data.second_ones);
				compare_field("shown_position", 4'(want.shown_position),
					4'(out_data.shown_position));
				compare_field("shown_value", want.shown_value, out_data.shown_value);
			end
		end
	end

	// buttons locked out by the reset debounce, scan at the reset rate
	task automatic test_reset_state();
		send_item(sample_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		send_item(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_set_buttons();
		reconfigure(16'hFFFF, 16'd0, 16'd1);
		send_item(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		send_item(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
		send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
		send_item(sample_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
		send_item(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		send_item(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
	endtask

	// zero periods advance on every tick, full debounce never lets a press through
	task automatic test_zero_periods_and_lockout();
		reconfigure(16'd0, 16'hFFFF, 16'd0);
		repeat (3) send_item(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_lowered_period();
		reconfigure(16'd1000, 16'd0, 16'd255);
		send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
		repeat (6) send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		reconfigure(16'd3, 16'd0, 16'd2);
		repeat (2) send_item(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	// set the clock just short of midnight, then let it run across
	task automatic test_midnight_rollover();
		int hours;
		int minutes;
		int seconds;
		int goal_s;
		int run;
		for (int seq = 0; seq < 4; seq++) begin
			reconfigure(16'($urandom_range(1, 3)), 16'd0, 16'($urandom_range(1, 6)));
			goal_s = $urandom_range(40, 58);
			for (int n = 0; n < 300; n++) begin
				hours = digit_q[POS_HOUR_TENS] * 10 + digit_q[POS_HOUR_ONES];
				minutes = digit_q[POS_MINUTE_TENS] * 10 + digit_q[POS_MINUTE_ONES];
				seconds = digit_q[POS_SECOND_TENS] * 10 + digit_q[POS_SECOND_ONES];
				if (hours == 23 && minutes == 59 && seconds >= goal_s) break;
				send_item(sample_of(1'b1, hours != 23, minutes != 59, seconds < goal_s, 1'b0));
			end
			run = $urandom_range(60, 200);
			repeat (run) begin
				send_item(sample_of($urandom_range(0, 7) != 0, $urandom_range(0, 39) == 0,
					1'b0, 1'b0, 1'b0));
			end
		end
	endtask

	task automatic test_random_traffic();
		in_item_t    it;
		logic [15:0] sec;
		logic [15:0] deb;
		logic [15:0] mux_word;
		for (int phase = 0; phase < 4; phase++) begin
			case ($urandom_range(0, 5))
				0: sec = 16'd0;
				1: sec = 16'hFFFF;
				2: sec = 16'($urandom_range(1, 65535));
				default: sec = 16'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 5))
				0: deb = 16'hFFFF;
				1: deb = 16'($urandom_range(0, 65535));
				2: deb = 16'd0;
				default: deb = 16'($urandom_range(0, 6));
			endcase
			case ($urandom_range(0, 4))
				0: mux_word[7:0] = 8'd255;
				1: mux_word[7:0] = 8'($urandom_range(0, 255));
				default: mux_word[7:0] = 8'($urandom_range(1, 6));
			endcase
			mux_word[15:8] = 8'($urandom_range(0, 255));
			reconfigure(sec, deb, mux_word);
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 49) == 0) steady = !steady;
				if ($urandom_range(0, 149) == 0) wait_idle();
				it.tick = $urandom_range(0, 9) != 0;
				it.hour_button = $urandom_range(0, 5) == 0;
				it.minute_button = $urandom_range(0, 5) == 0;
				it.second_button = $urandom_range(0, 5) == 0;
				it.clear_button = $urandom_range(0, 24) == 0;
				send_item(it);
			end
			steady = 1'b0;
		end
	endtask

	// full debounce keeps every press out over a long run, then the debounce is lowered by one and two more presses sent
	task automatic test_full_debounce_lockout();
		reconfigure(16'hFFFF, 16'hFFFF, 16'd255);
		steady = 1'b1;
		repeat (100) begin
			send_item(sample_of(1'b1, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
				$urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0));
		end
		steady = 1'b0;
		reconfigure(16'hFFFF, 16'hFFFE, 16'd255);
		send_item(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		send_item(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MS_PER_SECOND;
		cfg_data = '0;
		arst_n = 1'b0;
		sec_period = MS_PER_SECOND_RST;
		debounce_len = DEBOUNCE_MS_RST;
		scan_period = MUX_MS_RST;
		foreach (digit_q[i]) digit_q[i] = 4'd0;
		sec_ms = 16'd0;
		press_ms = 16'd0;
		scan_ms = 8'd0;
		scan_pos = POS_HOUR_TENS;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_set_buttons();
		test_zero_periods_and_lockout();
		test_lowered_period();
		test_midnight_rollover();
		test_random_traffic();
		test_full_debounce_lockout();
		wait_idle();
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
